@@ sv/swks_pkg.sv @@
// ----------------------------------------------------------------------------
// swks_pkg: shared constants for the k-smallest window sum block
// Register codes, cell operation codes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package swks_pkg;

   // configuration registers
   localparam int REG_W      = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic REG_WINDOW_LEN = 1'b0;
   localparam logic REG_KEEP_COUNT = 1'b1;

   localparam logic [REG_W-1:0] WINDOW_LEN_RESET = 7'd64;
   localparam logic [REG_W-1:0] KEEP_COUNT_RESET = 7'd1;

   // operation broadcast along the cell chain
   localparam int OP_W = 2;
   typedef logic [OP_W-1:0] cell_op_type;

   localparam cell_op_type OP_NONE = 2'd0;
   localparam cell_op_type OP_DEL  = 2'd1;
   localparam cell_op_type OP_INS  = 2'd2;
   localparam cell_op_type OP_CLR  = 2'd3;

endpackage

`default_nettype wire

@@ sv/sliding_window_k_smallest_sum.sv @@
// ----------------------------------------------------------------------------
// sliding_window_k_smallest_sum: sum of the smallest samples in a window
// Keeps the last window_len samples in a ring RAM and in a sorted cell
// chain, and keeps the sum of the keep_count smallest up to date.
// ----------------------------------------------------------------------------
//  port group  direction  carries
//  req_*       in         one sample word plus restart flag
//  rsp_*       out        small_sum once the window is full
//  csr_*       in/out     window_len (addr 0), keep_count (addr 4)
//
//  Words go back to back: one chain shift drops the oldest sample once the
//  window is full, one inserts the new one; the chain moves one slot per cycle.
//  A keep_count write starts a summing pass over min(keep_count, window)
//  slots of the chain with req_ready low.
//  Reset empties the window. The insert step holds while it would write a
//  result, the result register is full and rsp_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_k_smallest_sum #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,

   input  wire logic                                         req_valid,
   output logic                                              req_ready,
   input  wire logic [SAMPLE_BITS-1:0]                       req_sample,
   input  wire logic                                         req_restart,

   output logic                                              rsp_valid,
   input  wire logic                                         rsp_ready,
   output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]         rsp_small_sum,

   input  wire logic                                         csr_psel,
   input  wire logic                                         csr_penable,
   input  wire logic                                         csr_pwrite,
   input  wire logic [swks_pkg::CSR_ADDR_W-1:0]              csr_paddr,
   input  wire logic [swks_pkg::CSR_DATA_W-1:0]              csr_pwdata,
   output logic      [swks_pkg::CSR_DATA_W-1:0]              csr_prdata,
   output logic                                              csr_pready
);

   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W = (CNT_W > swks_pkg::REG_W) ? CNT_W : swks_pkg::REG_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DEL  = 2'd1;
   localparam logic [1:0] S_INS  = 2'd2;
   localparam logic [1:0] S_SUM  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [swks_pkg::REG_W-1:0] window_len_ff, window_len_in;
   logic [swks_pkg::REG_W-1:0] keep_count_ff, keep_count_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic [AW-1:0]              oldest_ff, oldest_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           sweep_ff, sweep_in;
   logic [SAMPLE_BITS-1:0]     sample_ff, sample_in;
   logic                       restart_ff, restart_in;
   logic                       full_ff, full_in;
   logic                       byp_ff, byp_in;
   logic [SAMPLE_BITS-1:0]     byp_data_ff, byp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]           rsp_sum_ff, rsp_sum_in;

   logic [CNT_W-1:0]           w_eff, k_eff, km1;
   logic [CMP_W-1:0]           wl_ext, kc_ext;
   logic [CNT_W-1:0]           oldest_nx;
   logic                       cfg_wr, wr_window, wr_keep;
   logic                       res, ins_go;

   swks_pkg::cell_op_type      chain_op;
   logic [SAMPLE_BITS-1:0]     chain_key, tap_data, del_key, ram_rdata;
   logic [CNT_W-1:0]           tap_idx;
   logic                       bound_hit;
   logic                       ram_we;
   logic [AW-1:0]              ram_waddr;

   // effective window and keep counts
   always_comb begin
      wl_ext = CMP_W'(window_len_ff);
      kc_ext = CMP_W'(keep_count_ff);
      if (wl_ext == '0) begin
         w_eff = CNT_W'(1);
      end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
         w_eff = CNT_W'(MAX_WINDOW);
      end else begin
         w_eff = wl_ext[CNT_W-1:0];
      end
      if (kc_ext > CMP_W'(w_eff)) begin
         k_eff = w_eff;
      end else begin
         k_eff = kc_ext[CNT_W-1:0];
      end
      km1 = k_eff - CNT_W'(1);
   end

   assign cfg_wr    = csr_psel && csr_penable && csr_pwrite;
   assign wr_window = cfg_wr && (csr_paddr[2] == swks_pkg::REG_WINDOW_LEN);
   assign wr_keep   = cfg_wr && (csr_paddr[2] == swks_pkg::REG_KEEP_COUNT);

   assign del_key   = byp_ff ? byp_data_ff : ram_rdata;
   assign oldest_nx = CNT_W'(oldest_ff) + CNT_W'(1);
   assign res       = (fill_ff + CNT_W'(1)) == w_eff;

   always_comb begin
      state_in      = state_ff;
      window_len_in = window_len_ff;
      keep_count_in = keep_count_ff;
      fill_in       = fill_ff;
      oldest_in     = oldest_ff;
      sum_in        = sum_ff;
      sweep_in      = sweep_ff;
      sample_in     = sample_ff;
      restart_in    = restart_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sum_in    = rsp_sum_ff;
      chain_op      = swks_pkg::OP_NONE;
      chain_key     = sample_ff;
      tap_idx       = k_eff;
      ram_we        = 1'b0;
      ram_waddr     = oldest_ff;
      ins_go        = 1'b0;
      req_ready     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_DEL;
            end
         end
         S_DEL: begin
            state_in = S_INS;
            if (restart_ff) begin
               chain_op  = swks_pkg::OP_CLR;
               fill_in   = '0;
               oldest_in = '0;
               sum_in    = '0;
               full_in   = 1'b0;
            end else if (fill_ff == w_eff) begin
               // drop the oldest word; tap gives the word that slides into
               // the kept range if the deleted one was inside it
               chain_op  = swks_pkg::OP_DEL;
               chain_key = del_key;
               tap_idx   = k_eff;
               if ((k_eff != '0) && bound_hit) begin
                  sum_in = sum_ff + SUM_W'(tap_data) - SUM_W'(del_key);
               end
               fill_in = fill_ff - CNT_W'(1);
               full_in = 1'b1;
            end else begin
               full_in = 1'b0;
            end
         end
         S_INS: begin
            tap_idx = km1;
            ins_go  = !res || !rsp_valid_ff || rsp_ready;
            if (ins_go) begin
               chain_op  = swks_pkg::OP_INS;
               chain_key = sample_ff;
               if ((k_eff != '0) && bound_hit) begin
                  sum_in = sum_ff + SUM_W'(sample_ff) - SUM_W'(tap_data);
               end
               fill_in = fill_ff + CNT_W'(1);
               ram_we  = 1'b1;
               if (full_ff) begin
                  ram_waddr = oldest_ff;
                  oldest_in = (oldest_nx == w_eff) ? '0 : oldest_nx[AW-1:0];
               end else begin
                  ram_waddr = fill_ff[AW-1:0];
               end
               if (res) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = sum_in;
               end
               req_ready = 1'b1;
               state_in  = req_valid ? S_DEL : S_IDLE;
            end
         end
         S_SUM: begin
            // rebuild the sum one slot per cycle after keep_count changes
            tap_idx = sweep_ff;
            if (sweep_ff == k_eff) begin
               state_in = S_IDLE;
            end else begin
               sum_in   = sum_ff + SUM_W'(tap_data);
               sweep_in = sweep_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (req_valid && req_ready) begin
         sample_in  = req_sample;
         restart_in = req_restart;
      end

      if (wr_window) begin
         window_len_in = csr_pwdata[swks_pkg::REG_W-1:0];
         fill_in       = '0;
         oldest_in     = '0;
         sum_in        = '0;
         chain_op      = swks_pkg::OP_CLR;
         state_in      = S_IDLE;
      end else if (wr_keep) begin
         keep_count_in = csr_pwdata[swks_pkg::REG_W-1:0];
         sum_in        = '0;
         sweep_in      = '0;
         state_in      = S_SUM;
      end
   end

   // read-during-write on the ring: forward the word just written
   assign byp_in      = ram_we && (ram_waddr == oldest_in);
   assign byp_data_in = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         window_len_ff <= swks_pkg::WINDOW_LEN_RESET;
         keep_count_ff <= swks_pkg::KEEP_COUNT_RESET;
         fill_ff       <= '0;
         oldest_ff     <= '0;
         sum_ff        <= '0;
         sweep_ff      <= '0;
         full_ff       <= 1'b0;
         byp_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         keep_count_ff <= keep_count_in;
         fill_ff       <= fill_in;
         oldest_ff     <= oldest_in;
         sum_ff        <= sum_in;
         sweep_ff      <= sweep_in;
         full_ff       <= full_in;
         byp_ff        <= byp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      restart_ff  <= restart_in;
      byp_data_ff <= byp_data_in;
      rsp_sum_ff  <= rsp_sum_in;
   end

   swks_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (sample_ff),
      .raddr (oldest_in),
      .rdata (ram_rdata)
   );

   swks_chain #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .op        (chain_op),
      .key       (chain_key),
      .tap_idx   (tap_idx),
      .bound_idx (km1),
      .tap_data  (tap_data),
      .bound_hit (bound_hit)
   );

   always_comb begin
      case (csr_paddr[2])
         swks_pkg::REG_WINDOW_LEN: csr_prdata = swks_pkg::CSR_DATA_W'(window_len_ff);
         swks_pkg::REG_KEEP_COUNT: csr_prdata = swks_pkg::CSR_DATA_W'(keep_count_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign csr_pready    = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_small_sum = rsp_sum_ff;

endmodule

`default_nettype wire

@@ sv/swks_ram.sv @@
// ----------------------------------------------------------------------------
// swks_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

@@ sv/swks_cell.sv @@
// ----------------------------------------------------------------------------
// swks_cell: one slot of the sorted sample chain
// Holds one sample and a valid flag; shifts with its neighbours on delete
// and insert so the chain stays in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module swks_cell #(
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire swks_pkg::cell_op_type   op,
   input  wire logic [SAMPLE_BITS-1:0]  key,
   input  wire logic [SAMPLE_BITS-1:0]  left_value,
   input  wire logic                    left_valid,
   input  wire logic                    left_cmp,
   input  wire logic [SAMPLE_BITS-1:0]  right_value,
   input  wire logic                    right_valid,
   output logic      [SAMPLE_BITS-1:0]  value,
   output logic                         valid,
   output logic                         cmp
);

   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic                   valid_ff, valid_in;

   // empty slots compare as "above everything"
   always_comb begin
      if (op == swks_pkg::OP_DEL) begin
         cmp = !valid_ff || (value_ff >= key);
      end else begin
         cmp = !valid_ff || (value_ff > key);
      end
   end

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (op)
         swks_pkg::OP_DEL: begin
            // everything from the first match upward moves down one slot
            if (cmp) begin
               value_in = right_value;
            end
            valid_in = right_valid;
         end
         swks_pkg::OP_INS: begin
            if (left_cmp) begin
               value_in = left_value;
            end else if (cmp) begin
               value_in = key;
            end
            valid_in = left_valid;
         end
         swks_pkg::OP_CLR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

@@ sv/swks_chain.sv @@
// ----------------------------------------------------------------------------
// swks_chain: sorted chain of sample cells
// Row of cells in ascending order, plus a tap that reads one slot and the
// compare flag of one slot for the running-sum update.
// ----------------------------------------------------------------------------
`default_nettype none

module swks_chain #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire swks_pkg::cell_op_type              op,
   input  wire logic [SAMPLE_BITS-1:0]             key,
   input  wire logic [$clog2(MAX_WINDOW+1)-1:0]    tap_idx,
   input  wire logic [$clog2(MAX_WINDOW+1)-1:0]    bound_idx,
   output logic      [SAMPLE_BITS-1:0]             tap_data,
   output logic                                    bound_hit
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   logic [SAMPLE_BITS-1:0] value_w [MAX_WINDOW];
   logic                   valid_w [MAX_WINDOW];
   logic                   cmp_w   [MAX_WINDOW];

   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      logic [SAMPLE_BITS-1:0] lv, rv;
      logic                   lval, lcmp, rval;

      if (g == 0) begin : g_first
         assign lv   = '0;
         assign lval = 1'b1;
         assign lcmp = 1'b0;
      end else begin : g_mid_l
         assign lv   = value_w[g-1];
         assign lval = valid_w[g-1];
         assign lcmp = cmp_w[g-1];
      end

      if (g == MAX_WINDOW - 1) begin : g_last
         assign rv   = '0;
         assign rval = 1'b0;
      end else begin : g_mid_r
         assign rv   = value_w[g+1];
         assign rval = valid_w[g+1];
      end

      swks_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .key         (key),
         .left_value  (lv),
         .left_valid  (lval),
         .left_cmp    (lcmp),
         .right_value (rv),
         .right_valid (rval),
         .value       (value_w[g]),
         .valid       (valid_w[g]),
         .cmp         (cmp_w[g])
      );
   end

   // empty slots read as zero; an index past the chain selects nothing
   always_comb begin
      tap_data  = '0;
      bound_hit = 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (valid_w[i] && (CNT_W'(i) == tap_idx)) begin
            tap_data = tap_data | value_w[i];
         end
         if (CNT_W'(i) == bound_idx) begin
            bound_hit = bound_hit | cmp_w[i];
         end
      end
   end

endmodule

`default_nettype wire
